// File: rtl/core/rpi_pkg.sv
// Shared types and constants of the radial profile interpolator.
package rpi_pkg;
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_POINTS = 1'b1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam int ABS_W = 17;
	localparam int VAL_W = 32;
	localparam int DIST_W = 17;

	// Segment hit handed from one table cell to the next.
	typedef struct packed {
		logic             found;
		logic [ABS_W-1:0] a0;
		logic [ABS_W-1:0] a1;
		logic [VAL_W-1:0] w0;
		logic [VAL_W-1:0] w1;
	} seg_t;
endpackage

// File: rtl/core/rpi_cell.sv
// One table cell: holds a point and checks the segment it opens.
module rpi_cell (
	input  logic                         clk,
	input  logic                         wr,
	input  logic [rpi_pkg::ABS_W-1:0]    wr_abs,
	input  logic [rpi_pkg::VAL_W-1:0]    wr_val,
	input  logic                         chk,
	input  logic [rpi_pkg::DIST_W-1:0]   dist_in,
	input  logic [rpi_pkg::ABS_W-1:0]    next_abs,
	input  logic [rpi_pkg::VAL_W-1:0]    next_val,
	input  rpi_pkg::seg_t                seg_in,
	output rpi_pkg::seg_t                seg_out,
	output logic [rpi_pkg::ABS_W-1:0]    abs_out,
	output logic [rpi_pkg::VAL_W-1:0]    val_out
);
	logic [rpi_pkg::ABS_W-1:0] abs_q;
	logic [rpi_pkg::VAL_W-1:0] val_q;
	rpi_pkg::seg_t             hit;
	rpi_pkg::seg_t             seg_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			abs_q <= wr_abs;
			val_q <= wr_val;
		end
	end

	assign abs_out = abs_q;
	assign val_out = val_q;

	// later cells override: highest matching index wins
	always_comb begin
		hit = seg_in;
		if (chk && dist_in >= abs_q && dist_in < next_abs) begin
			hit.found = 1'b1;
			hit.a0 = abs_q;
			hit.a1 = next_abs;
			hit.w0 = val_q;
			hit.w1 = next_val;
		end
	end

	// one cell per cycle along the chain
	always_ff @(posedge clk) begin
		seg_q <= hit;
	end

	assign seg_out = seg_q;
endmodule

// File: rtl/core/rpi_divider.sv
// Restoring divider, one quotient bit per cycle.
module rpi_divider #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

// File: rtl/core/radial_profile_interpolator_core.sv
// Top level: radial profile interpolator with a chain of table cells.
//
// channel | ports                                             | handshake
// --------+---------------------------------------------------+-----------------
// input   | command point_index abscissa profile_value x_pos y_pos | start & !busy
// result  | opening outside no_segment                        | result_valid
// config  | cfg_we cfg_index cfg_data                         | cfg_we
//
// A load never raises busy. A query keeps busy high through squaring and
// summing, a 32-step bit-pair square root, the normalizing divide, the ripple
// of the segment hit through the cell chain, one multiply, the slope divide
// and the output state; the result strobe comes in the same cycle that busy
// falls. A zero radius skips from the square root straight to the output.
// Reset clears control only; the table is valid once written. The receiver
// cannot stall: the result strobe lasts one cycle.
module radial_profile_interpolator_core #(
	parameter int TABLE_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [5:0]  point_index,
	input  logic [16:0] abscissa,
	input  logic [31:0] profile_value,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	input  logic        cfg_we,
	input  logic [rpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpi_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic        result_valid,
	output logic [31:0] opening,
	output logic        outside,
	output logic        no_segment
);
	localparam int N = TABLE_POINTS;
	localparam int PW = $clog2(N + 1) > 7 ? $clog2(N + 1) : 7;
	localparam int CW = $clog2(N + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_SQ = 4'd1, ST_SUM = 4'd2,
		ST_ROOT = 4'd3, ST_NDIV = 4'd4, ST_NWAIT = 4'd5, ST_CHAIN = 4'd6,
		ST_MUL = 4'd7, ST_SDIV = 4'd8, ST_SWAIT = 4'd9, ST_OUT = 4'd10;

	logic [3:0]  state_q;
	logic [31:0] radius_q;
	logic [6:0]  points_q;
	logic [31:0] ax_q, ay_q;
	logic [63:0] sx_q, sy_q, v_q, res_q, bit_q;
	logic [5:0]  rcnt_q;
	logic [16:0] dist_q;
	logic [CW-1:0] chain_q;
	rpi_pkg::seg_t seg_q;
	logic        neg_q;
	logic [48:0] prod_q;

	// root step
	logic [63:0] rsum;
	assign rsum = res_q + bit_q;

	// table chain
	logic [rpi_pkg::ABS_W-1:0] cabs [N+1];
	logic [rpi_pkg::VAL_W-1:0] cval [N+1];
	rpi_pkg::seg_t             cseg [N+1];
	logic [PW-1:0] n_eff;
	assign n_eff = ({{(PW-7){1'b0}}, points_q} > PW'(N)) ? PW'(N)
		: {{(PW-7){1'b0}}, points_q};
	assign cseg[0] = '0;
	assign cabs[N] = '0;
	assign cval[N] = '0;

	genvar g;
	for (g = 0; g < N; g++) begin : g_cell
		logic chk;
		assign chk = (state_q == ST_CHAIN) && (PW'(g + 1) < n_eff);
		rpi_cell u_cell (
			.clk(clk),
			.wr(start && !busy && command == rpi_pkg::CMD_LOAD
				&& PW'(point_index) == PW'(g)),
			.wr_abs(abscissa), .wr_val(profile_value),
			.chk(chk), .dist_in(dist_q),
			.next_abs(cabs[g+1]), .next_val(cval[g+1]),
			.seg_in(cseg[g]), .seg_out(cseg[g+1]),
			.abs_out(cabs[g]), .val_out(cval[g])
		);
	end

	// shared divider
	logic        dgo, ddone;
	logic [47:0] dnum, dquo;
	logic [31:0] dden;
	rpi_divider #(.NUM_W(48), .DEN_W(32)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);
	assign dgo = (state_q == ST_NDIV) || (state_q == ST_SDIV);
	always_comb begin
		if (state_q == ST_NDIV) begin
			dnum = {res_q[31:0], 16'd0};
			dden = radius_q;
		end else begin
			dnum = prod_q[47:0];
			dden = {15'd0, seg_q.a1 - seg_q.a0};
		end
	end

	// slope sign and magnitude of the captured segment
	logic [32:0] wdiff;
	logic [31:0] wmag;
	assign wdiff = {1'b0, seg_q.w1} - {1'b0, seg_q.w0};
	assign wmag  = wdiff[32] ? 32'(-wdiff) : wdiff[31:0];

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			radius_q     <= 32'd65536;
			points_q     <= 7'd64;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == rpi_pkg::REG_RADIUS) radius_q <= cfg_data;
				else points_q <= cfg_data[6:0];
			end
			case (state_q)
				ST_IDLE: if (start && command == rpi_pkg::CMD_QUERY) state_q <= ST_SQ;
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_ROOT;
				ST_ROOT: if (rcnt_q == 6'd0) state_q <= ST_NDIV;
				ST_NDIV: begin
					if (radius_q == 32'd0) state_q <= ST_OUT;
					else state_q <= ST_NWAIT;
				end
				ST_NWAIT: if (ddone) state_q <= ST_CHAIN;
				ST_CHAIN: if (chain_q == '0) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SDIV;
				ST_SDIV: state_q <= ST_SWAIT;
				ST_SWAIT: if (ddone) state_q <= ST_OUT;
				ST_OUT: begin
					state_q <= ST_IDLE;
					result_valid <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q <= x_pos[31] ? 32'(-x_pos) : x_pos;
				ay_q <= y_pos[31] ? 32'(-y_pos) : y_pos;
				outside <= 1'b0;
			end
			ST_SQ: begin
				sx_q <= ax_q * ax_q;
				sy_q <= ay_q * ay_q;
			end
			ST_SUM: begin
				v_q    <= sx_q + sy_q;
				res_q  <= '0;
				bit_q  <= 64'd1 << 62;
				rcnt_q <= 6'd31;
			end
			ST_ROOT: begin
				if (v_q >= rsum) begin
					v_q   <= v_q - rsum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				rcnt_q <= rcnt_q - 6'd1;
			end
			ST_NDIV: if (radius_q == 32'd0) outside <= 1'b1;
			ST_NWAIT: if (ddone) begin
				outside <= (dquo[47:16] != 32'd0);
				dist_q  <= dquo[16:0];
				chain_q <= CW'(N);
			end
			// chain_q counts down while the hit ripples to the end of the chain
			ST_CHAIN: begin
				if (chain_q == '0) seg_q <= cseg[N];
				else chain_q <= chain_q - 1'b1;
			end
			ST_MUL: begin
				neg_q  <= wdiff[32];
				prod_q <= 49'(wmag) * 49'(dist_q - seg_q.a0);
			end
			ST_SDIV: ;
			default: ;
		endcase
		if (state_q == ST_SWAIT && ddone) begin
			opening    <= (outside || !seg_q.found) ? 32'd0
				: (neg_q ? seg_q.w0 - dquo[31:0] : seg_q.w0 + dquo[31:0]);
			no_segment <= !outside && !seg_q.found;
		end
		if (state_q == ST_NDIV && radius_q == 32'd0) begin
			opening    <= 32'd0;
			no_segment <= 1'b0;
		end
	end
endmodule

// File: sim/tb_radial_profile_interpolator_core.sv
// Self-checking testbench of the radial profile interpolator core.
module tb_radial_profile_interpolator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	// Pause before a register write: well past one query.
	localparam int SETTLE_CYCLES = 300;
	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASES = 10;

	typedef struct {
		logic [31:0] opening;
		logic        outside;
		logic        no_segment;
	} profile_res_t;

	typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;

	// One directed row; a typed expectation replaces the prediction when set.
	typedef struct {
		row_kind_t    kind;
		logic [5:0]   idx;
		logic [16:0]  absc;
		logic [31:0]  data;
		logic [31:0]  xq;
		logic [31:0]  yq;
		bit           typed;
		profile_res_t res;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [5:0]  point_index;
	logic [16:0] abscissa;
	logic [31:0] profile_value;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic        cfg_we;
	logic [rpi_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rpi_pkg::CFG_DATA_W-1:0] cfg_data;
	logic        result_valid;
	logic [31:0] opening;
	logic        outside;
	logic        no_segment;

	// Shadow state of the block
	logic [16:0] knot_abscissa [DEPTH];
	logic [31:0] knot_value [DEPTH];
	logic [31:0] cur_radius;
	logic [6:0]  cur_points;

	profile_res_t pending_profiles[$];
	int          failures;
	int          cycles;
	bit          gaps_on;
	plan_row_t   plan[$];

	radial_profile_interpolator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.point_index  (point_index),
		.abscissa     (abscissa),
		.profile_value(profile_value),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.opening      (opening),
		.outside      (outside),
		.no_segment   (no_segment)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] floor_root64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] probe;
		rem = v;
		root = 0;
		probe = 64'h1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] coord_mag(input logic [31:0] c);
		return c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
	endfunction

	// Profile value at (xq, yq) under the shadow table and registers.
	function automatic profile_res_t profile_at(input logic [31:0] xq, input logic [31:0] yq);
		profile_res_t res;
		logic [63:0]  ax;
		logic [63:0]  ay;
		logic [63:0]  norm_d;
		logic [63:0]  a0;
		logic [63:0]  a1;
		longint       w0;
		longint       w1;
		longint       q;
		int           n;
		bit           hit;
		res = '{opening: 32'd0, outside: 1'b1, no_segment: 1'b0};
		hit = 0;
		ax = coord_mag(xq);
		ay = coord_mag(yq);
		if (cur_radius == 0)
			return res;
		norm_d = (floor_root64(ax * ax + ay * ay) << 16) / {32'd0, cur_radius};
		if (norm_d >= 64'd65536)
			return res;
		res.outside = 1'b0;
		n = (cur_points > DEPTH) ? DEPTH : int'(cur_points);
		for (int i = 0; i + 1 < n; i++) begin
			a0 = {47'd0, knot_abscissa[i]};
			a1 = {47'd0, knot_abscissa[i+1]};
			if (norm_d >= a0 && norm_d < a1) begin
				w0 = longint'({32'd0, knot_value[i]});
				w1 = longint'({32'd0, knot_value[i+1]});
				q = ((w1 - w0) * longint'(norm_d - a0)) / longint'(a1 - a0);
				res.opening = 32'(w0 + q);
				hit = 1;
			end
		end
		if (!hit)
			res.opening = 32'd0;
		res.no_segment = !hit;
		return res;
	endfunction

	// Result checker: every strobe must match the oldest pending transaction.
	always @(posedge clk) begin
		profile_res_t want;
		if (arst_n && result_valid) begin
			if (pending_profiles.size() == 0) begin
				$error("unexpected result: opening=%h outside=%b no_segment=%b",
					opening, outside, no_segment);
				failures++;
			end else begin
				want = pending_profiles.pop_front();
				if (opening !== want.opening) begin
					$error("opening: expected %h, got %h", want.opening, opening);
					failures++;
				end
				if (outside !== want.outside) begin
					$error("outside: expected %b, got %b", want.outside, outside);
					failures++;
				end
				if (no_segment !== want.no_segment) begin
					$error("no_segment: expected %b, got %b", want.no_segment, no_segment);
					failures++;
				end
			end
		end
	end

	// Drive one transaction; returns once the block has taken it.
	task automatic issue(input logic cmd, input logic [5:0] idx, input logic [16:0] absc,
			input logic [31:0] val, input logic [31:0] xq, input logic [31:0] yq,
			input bit typed, input profile_res_t typed_res);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 99) < 31) begin
			start = 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < 31);
		end
		start = 1'b1;
		command = cmd;
		point_index = idx;
		abscissa = absc;
		profile_value = val;
		x_pos = xq;
		y_pos = yq;
		do @(posedge clk); while (busy);
		if (cmd == rpi_pkg::CMD_LOAD) begin
			knot_abscissa[idx] = absc;
			knot_value[idx] = val;
		end else begin
			pending_profiles = {pending_profiles, typed ? typed_res : profile_at(xq, yq)};
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_profiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, only while the block is idle.
	task automatic write_reg(input logic [rpi_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == rpi_pkg::REG_RADIUS)
			cur_radius = val;
		else
			cur_points = val[6:0];
	endtask

	function automatic logic [31:0] pick_coord();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(0, 31);
			2, 3: v = (cur_radius == 0) ? $urandom :
				($urandom % cur_radius) >> $urandom_range(0, 1);
			default: v = $urandom_range(0, 3);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic logic [31:0] pick_radius();
		case ($urandom_range(0, 5))
			0: return 32'd65536;
			1: return $urandom;
			2: return $urandom >> $urandom_range(0, 31);
			3: return 32'hFFFF_FFFF;
			4: return 32'd1;
			default: return ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(4096, 1 << 24);
		endcase
	endfunction

	function automatic logic [6:0] pick_points();
		case ($urandom_range(0, 3))
			0: return 7'd64;
			1: return 7'($urandom_range(0, 127));
			default: return 7'($urandom_range(2, 64));
		endcase
	endfunction

	function automatic plan_row_t row(input row_kind_t kind, input logic [5:0] idx,
			input logic [16:0] absc, input logic [31:0] data, input logic [31:0] xq,
			input logic [31:0] yq, input bit typed, input profile_res_t res);
		plan_row_t r;
		r = '{kind, idx, absc, data, xq, yq, typed, res};
		return r;
	endfunction

	initial begin
		profile_res_t none;
		profile_res_t out_res;
		profile_res_t noseg_res;
		plan_row_t    p;
		logic [16:0]  absc;
		int           idx;

		none = '{opening: 32'd0, outside: 1'b0, no_segment: 1'b0};
		out_res = '{opening: 32'd0, outside: 1'b1, no_segment: 1'b0};
		noseg_res = '{opening: 32'd0, outside: 1'b0, no_segment: 1'b1};
		failures = 0;
		cycles = 0;
		gaps_on = 1;
		start = 1'b0;
		command = rpi_pkg::CMD_LOAD;
		point_index = '0;
		abscissa = '0;
		profile_value = '0;
		x_pos = '0;
		y_pos = '0;
		cfg_we = 1'b0;
		cfg_index = rpi_pkg::REG_RADIUS;
		cfg_data = '0;
		cur_radius = 32'd65536;
		cur_points = 7'd64;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the whole table first so no query ever reads an unwritten point.
		// Points 0..2 swing between the value extremes for the steepest slopes.
		for (int i = 0; i < DEPTH; i++) begin
			issue(rpi_pkg::CMD_LOAD, 6'(i), 17'((i * 65536) / (DEPTH - 1)),
				(i == 1) ? 32'hFFFF_FFFF : (i == 0 || i == 2) ? 32'd0 : $urandom,
				32'd0, 32'd0, 0, none);
		end

		// Directed part
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd0, 32'd0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd65536, 32'd0, 1, out_res)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1, out_res)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, out_res)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd65535, 32'd0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, -32'd1000, 32'd500, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd1040, 32'd0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, -32'd700, -32'd900, 0, none)};
		// abscissa above one, stored and compared as given
		plan = {plan, row(ROW_LOAD, 63, 17'h1FFFF, 32'hFFFF_FFFF, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd65500, 32'd0, 0, none)};
		// table not ascending: several segments match, highest index wins
		plan = {plan, row(ROW_LOAD, 5, 17'd0, 32'd12345, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd3000, 32'd1500, 0, none)};
		// zero radius: always outside
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_RADIUS, 0, 32'd0, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd0, 32'd0, 1, out_res)};
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_RADIUS, 0, 32'hFFFF_FFFF, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, none)};
		// fewer than two points in use: no segment at all
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_POINTS, 0, 32'd0, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd0, 32'd0, 1, noseg_res)};
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_POINTS, 0, 32'd1, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd5, 32'd7, 1, noseg_res)};
		// more points than the table holds: clamped
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_POINTS, 0, 32'd127, 0, 0, 0, none)};
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_RADIUS, 0, 32'd1, 0, 0, 0, none)};
		plan = {plan, row(ROW_QUERY, 0, 0, 0, 32'd0, 32'd0, 0, none)};
		plan = {plan, row(ROW_CFG, rpi_pkg::REG_RADIUS, 0, 32'd65536, 0, 0, 0, none)};

		foreach (plan[i]) begin
			p = plan[i];
			case (p.kind)
				ROW_LOAD:  issue(rpi_pkg::CMD_LOAD, p.idx, p.absc, p.data, 0, 0, 0, none);
				ROW_QUERY: issue(rpi_pkg::CMD_QUERY, 0, 0, 0, p.xq, p.yq, p.typed, p.res);
				default:   write_reg(p.idx[rpi_pkg::CFG_IDX_W-1:0], p.data);
			endcase
		end

		// Random part, in phases of register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(rpi_pkg::REG_RADIUS, pick_radius());
			write_reg(rpi_pkg::REG_POINTS, {25'd0, pick_points()});
			gaps_on = (ph != PHASES / 2);
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					idx = $urandom_range(0, DEPTH - 1);
					// mostly a roughly ascending table, sometimes any 17-bit value
					absc = ($urandom_range(0, 7) == 0) ? 17'($urandom) :
						17'(idx * 1024 + $urandom_range(0, 1000));
					issue(rpi_pkg::CMD_LOAD, 6'(idx), absc, $urandom, $urandom, $urandom,
						0, none);
				end else begin
					issue(rpi_pkg::CMD_QUERY, 6'($urandom), 17'($urandom), $urandom,
						pick_coord(), pick_coord(), 0, none);
				end
			end
		end

		drain();
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: radial_profile_interpolator_core.f
rtl/core/rpi_pkg.sv
rtl/core/rpi_cell.sv
rtl/core/rpi_divider.sv
rtl/core/radial_profile_interpolator_core.sv
sim/tb_radial_profile_interpolator_core.sv
